### sv/paper_texture_noise_shader_top_defines.svh
// assertion macros shared by the paper texture shader checker
`ifndef PAPER_TEXTURE_NOISE_SHADER_TOP_DEFINES_SVH
`define PAPER_TEXTURE_NOISE_SHADER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while reset is asserted
`define PTN_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while reset is asserted
`define PTN_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/ptn_pkg.sv
// shared constants, types and helpers of the paper texture shader
package ptn_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int INV_BITS       = 24;

	// corner hash multipliers
	localparam logic [31:0] HASH_X   = 32'd374761393;
	localparam logic [31:0] HASH_Y   = 32'd668265263;
	localparam logic [31:0] HASH_S   = 32'd1442695041;
	localparam logic [31:0] HASH_MIX = 32'd1274126177;

	// layer blend weights, q2.16 (green and blue: q0.16)
	localparam logic [17:0] COEF_BROAD  = 18'd157286;
	localparam logic [17:0] COEF_MEDIUM = 18'd81920;
	localparam logic [17:0] COEF_FINE   = 18'd42598;
	localparam logic [15:0] COEF_GREEN  = 16'd60293;
	localparam logic [15:0] COEF_BLUE   = 16'd51118;

	// base paper color
	localparam int BASE_RED   = 251;
	localparam int BASE_GREEN = 249;
	localparam int BASE_BLUE  = 242;

	// layer geometry
	localparam int BROAD_SCALE  = 7;
	localparam int BROAD_OFF    = 0;
	localparam int BROAD_OCT    = 3;
	localparam int MEDIUM_SCALE = 24;
	localparam int MEDIUM_OFF   = 71;
	localparam int MEDIUM_OCT   = 3;
	localparam int FINE_SCALE   = 100;
	localparam int FINE_OFF     = 113;
	localparam int FINE_OCT     = 2;
	localparam int AGE_SCALE    = 5;
	localparam int AGE_OFF      = 200;
	localparam int AGE_OCT      = 2;

	// pipeline depths
	localparam int NOISE_LAT   = 7;
	localparam int FRACTAL_LAT = 2;
	localparam int MIX_LAT     = 4;

	localparam logic [15:0] GRAIN_RESET = 16'd256;
	localparam logic [31:0] KG_GREEN_RESET = 32'(256 * 60293);
	localparam logic [31:0] KG_BLUE_RESET  = 32'(256 * 51118);

	typedef enum logic [2:0] {
		REG_SEED       = 3'd0,
		REG_INV_WIDTH  = 3'd1,
		REG_INV_HEIGHT = 3'd2,
		REG_GRAIN      = 3'd3,
		REG_AGING      = 3'd4
	} cfg_reg_t;

	// gains plus grain pre-scaled by the green and blue weights
	typedef struct packed {
		logic [15:0] grain;
		logic [15:0] aging;
		logic [31:0] kg_green;
		logic [31:0] kg_blue;
	} gain_cfg_t;

	// constant part of the seed hash term for a layer offset and octave
	function automatic logic [31:0] seed_offset_term(input int unsigned off);
		logic [63:0] p;
		p = 64'(off) * 64'(HASH_S);
		return p[31:0];
	endfunction

endpackage

### sv/ptn_noise.sv
// one octave of hashed gradient noise, seven register stages
module ptn_noise import ptn_pkg::*; #(
	parameter int CW        = 36,
	parameter int FRAC_BITS = 16,
	parameter int SCALE     = 7,
	parameter int SHIFT     = 0
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [CW-1:0]               cx,
	input  logic [CW-1:0]               cy,
	input  logic [31:0]                 seed_term,
	output logic signed [FRAC_BITS+3:0] n
);

	localparam int F  = FRAC_BITS;
	localparam int PW = CW + 9;
	localparam int IW = PW - 24;
	localparam int NW = F + 4;
	localparam int DW = F + 3;
	localparam int GW = F + 2;

	localparam logic [F+1:0]          THREE = (F + 2)'(3) << F;
	localparam logic signed [GW-1:0]  ONE_G = GW'(1 << F);
	localparam logic signed [DW-1:0]  ONE_D = DW'(1 << F);
	localparam logic signed [DW-1:0]  TWO_D = DW'(2 << F);

	// stage 1: scaled position
	logic [PW-1:0] px, py;
	logic [IW-1:0] ix_s1, iy_s1;
	logic [F-1:0]  fx_s1, fy_s1;

	assign px = (PW'(cx) * PW'(SCALE)) << SHIFT;
	assign py = (PW'(cy) * PW'(SCALE)) << SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			ix_s1 <= px[PW-1:24];
			iy_s1 <= py[PW-1:24];
			fx_s1 <= px[23:24-F];
			fy_s1 <= py[23:24-F];
		end
	end

	// stage 2: cell hash products, fraction squares
	logic [31:0]    ixw, iyw;
	logic [2*F-1:0] fxx, fyy;
	logic [31:0]    ixa_s2, iyb_s2;
	logic [F-1:0]   fx2_s2, fy2_s2, fx_s2, fy_s2;

	assign ixw = 32'(ix_s1);
	assign iyw = 32'(iy_s1);
	assign fxx = fx_s1 * fx_s1;
	assign fyy = fy_s1 * fy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ixa_s2 <= ixw * HASH_X;
			iyb_s2 <= iyw * HASH_Y;
			fx2_s2 <= fxx[2*F-1:F];
			fy2_s2 <= fyy[2*F-1:F];
			fx_s2  <= fx_s1;
			fy_s2  <= fy_s1;
		end
	end

	// stage 3: corner hash mix, smoothstep
	logic [31:0]    h0 [4];
	logic [31:0]    hm [4];
	logic [F+1:0]   tx, ty;
	logic [2*F+1:0] spx, spy;
	logic [31:0]    hm_s3 [4];
	logic [F:0]     sx_s3, sy_s3;
	logic [F-1:0]   fx_s3, fy_s3;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			h0[c] = ixa_s2 + iyb_s2 + seed_term + ((c % 2) != 0 ? HASH_X : 32'd0)
				+ ((c / 2) != 0 ? HASH_Y : 32'd0);
			hm[c] = (h0[c] ^ (h0[c] >> 13)) * HASH_MIX;
		end
	end

	assign tx  = THREE - {1'b0, fx_s2, 1'b0};
	assign ty  = THREE - {1'b0, fy_s2, 1'b0};
	assign spx = fx2_s2 * tx;
	assign spy = fy2_s2 * ty;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++)
				hm_s3[c] <= hm[c];
			sx_s3 <= spx[2*F:F];
			sy_s3 <= spy[2*F:F];
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
		end
	end

	// stage 4: gradients times corner offsets
	logic [31:0]              hf [4];
	logic signed [GW-1:0]     g [4];
	logic signed [DW-1:0]     d [4];
	logic [DW-1:0]            fsum;
	logic signed [DW+GW-1:0]  prod_s4 [4];
	logic [F:0]               sx_s4, sy_s4;

	assign fsum = DW'(fx_s3) + DW'(fy_s3);

	always_comb begin
		d[0] = $signed(fsum);
		d[1] = $signed(fsum) - ONE_D;
		d[2] = $signed(fsum) - ONE_D;
		d[3] = $signed(fsum) - TWO_D;
		for (int c = 0; c < 4; c++) begin
			hf[c] = hm_s3[c] ^ (hm_s3[c] >> 16);
			g[c]  = $signed({1'b0, hf[c][30:30-F]}) - ONE_G;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++)
				prod_s4[c] <= d[c] * g[c];
			sx_s4 <= sx_s3;
			sy_s4 <= sy_s3;
		end
	end

	// stage 5: corner values, blend along x
	logic signed [NW-1:0]    v [4];
	logic signed [NW:0]      dx0, dx1;
	logic signed [F+1:0]     sxs;
	logic signed [NW+F+2:0]  ab0_s5, ab1_s5;
	logic signed [NW-1:0]    v00_s5, v01_s5;
	logic [F:0]              sy_s5;

	always_comb begin
		for (int c = 0; c < 4; c++)
			v[c] = $signed(prod_s4[c][F+NW-1:F]);
	end

	assign dx0 = (NW + 1)'(v[1]) - (NW + 1)'(v[0]);
	assign dx1 = (NW + 1)'(v[3]) - (NW + 1)'(v[2]);
	assign sxs = $signed({1'b0, sx_s4});

	always_ff @(posedge clk) begin
		if (en) begin
			ab0_s5 <= dx0 * sxs;
			ab1_s5 <= dx1 * sxs;
			v00_s5 <= v[0];
			v01_s5 <= v[2];
			sy_s5  <= sy_s4;
		end
	end

	// stage 6: finish x blends, blend along y
	logic signed [NW:0]      x0w, x1w, dyv;
	logic signed [NW-1:0]    x0, x1;
	logic signed [F+1:0]     sys;
	logic signed [NW+F+2:0]  pyv_s6;
	logic signed [NW-1:0]    x0_s6;

	assign x0w = (NW + 1)'(v00_s5) + $signed(ab0_s5[F+NW:F]);
	assign x1w = (NW + 1)'(v01_s5) + $signed(ab1_s5[F+NW:F]);
	assign x0  = $signed(x0w[NW-1:0]);
	assign x1  = $signed(x1w[NW-1:0]);
	assign dyv = (NW + 1)'(x1) - (NW + 1)'(x0);
	assign sys = $signed({1'b0, sy_s5});

	always_ff @(posedge clk) begin
		if (en) begin
			pyv_s6 <= dyv * sys;
			x0_s6  <= x0;
		end
	end

	// stage 7: noise value
	logic signed [NW:0]   nw;
	logic signed [NW-1:0] n_s7;

	assign nw = (NW + 1)'(x0_s6) + $signed(pyv_s6[F+NW:F]);

	always_ff @(posedge clk) begin
		if (en)
			n_s7 <= $signed(nw[NW-1:0]);
	end

	assign n = n_s7;

endmodule

### sv/ptn_fractal.sv
// fractal sum of noise octaves with weight-total division
module ptn_fractal import ptn_pkg::*; #(
	parameter int CW        = 36,
	parameter int FRAC_BITS = 16,
	parameter int SCALE     = 7,
	parameter int OFFSET    = 0,
	parameter int OCTAVES   = 3
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [CW-1:0]               cx,
	input  logic [CW-1:0]               cy,
	input  logic [31:0]                 seed_c,
	output logic signed [FRAC_BITS+3:0] frac
);

	localparam int NW = FRAC_BITS + 4;
	localparam int AW = NW + 3;
	localparam int D  = (1 << OCTAVES) - 1;
	localparam logic [AW-1:0] DIV   = AW'(D);
	localparam logic [AW-1:0] RECIP = AW'((64'd1 << AW) / D);

	logic signed [NW-1:0] n [OCTAVES];

	for (genvar i = 0; i < OCTAVES; i++) begin : g_oct
		ptn_noise #(
			.CW(CW),
			.FRAC_BITS(FRAC_BITS),
			.SCALE(SCALE),
			.SHIFT(i)
		) u_noise (
			.clk(clk),
			.en(en),
			.cx(cx),
			.cy(cy),
			.seed_term(seed_c + seed_offset_term(OFFSET + i)),
			.n(n[i])
		);
	end

	// weighted sum, magnitude, reciprocal product
	logic signed [AW-1:0] sum;
	logic [AW-1:0]        mag;
	logic [2*AW-1:0]      qp;
	logic [AW-1:0]        q0_s1, mag_s1;
	logic                 neg_s1;

	always_comb begin
		sum = '0;
		for (int i = 0; i < OCTAVES; i++)
			sum = sum + (AW'(n[i]) <<< (OCTAVES - 1 - i));
	end

	assign mag = sum[AW-1] ? AW'(-sum) : AW'(sum);
	assign qp  = mag * RECIP;

	always_ff @(posedge clk) begin
		if (en) begin
			q0_s1  <= qp[2*AW-1:AW];
			mag_s1 <= mag;
			neg_s1 <= sum[AW-1];
		end
	end

	// one correction step, sign restored (truncation toward zero)
	logic [AW-1:0]        rem, q;
	logic signed [NW-1:0] frac_s2;

	assign rem = mag_s1 - q0_s1 * DIV;
	assign q   = q0_s1 + AW'(rem >= DIV);

	always_ff @(posedge clk) begin
		if (en)
			frac_s2 <= neg_s1 ? $signed(NW'(-q)) : $signed(NW'(q));
	end

	assign frac = frac_s2;

endmodule

### sv/ptn_mix.sv
// layer blend, gains, base color and channel clamp
module ptn_mix import ptn_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [FRAC_BITS+3:0] broad,
	input  logic signed [FRAC_BITS+3:0] mid,
	input  logic signed [FRAC_BITS+3:0] fine,
	input  logic signed [FRAC_BITS+3:0] age,
	input  gain_cfg_t                   gains,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue
);

	localparam int F   = FRAC_BITS;
	localparam int NW  = F + 4;
	localparam int TW  = NW + 19;
	localparam int VW  = NW + 5;
	localparam int CWD = VW + 20;
	localparam logic signed [NW:0]    HALF   = (NW + 1)'(1 << (F - 1));
	localparam logic signed [CWD-1:0] BASE_R = CWD'(BASE_RED) <<< (F + 8);
	localparam logic signed [CWD-1:0] BASE_G = CWD'(BASE_GREEN) <<< (F + 8);
	localparam logic signed [CWD-1:0] BASE_B = CWD'(BASE_BLUE) <<< (F + 8);

	function automatic logic [7:0] clamp8(input logic signed [CWD-1:0] v);
		if (v[CWD-1])
			return 8'd0;
		else if (|v[CWD-2:F+16])
			return 8'd255;
		else
			return v[F+15:F+8];
	endfunction

	// m1: weighted layers, age remap
	logic signed [TW-1:0] tb_s1, tm_s1, tf_s1;
	logic signed [NW:0]   agen_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			tb_s1   <= broad * $signed({1'b0, COEF_BROAD});
			tm_s1   <= mid * $signed({1'b0, COEF_MEDIUM});
			tf_s1   <= fine * $signed({1'b0, COEF_FINE});
			agen_s1 <= (NW + 1)'(age >>> 1) + HALF;
		end
	end

	// m2: variation
	logic signed [TW+1:0] vsum;
	logic signed [VW-1:0] var_s2;
	logic signed [NW:0]   agen_s2;

	assign vsum = (TW + 2)'(tb_s1) + (TW + 2)'(tm_s1) + (TW + 2)'(tf_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			var_s2  <= $signed(vsum[16+VW-1:16]);
			agen_s2 <= agen_s1;
		end
	end

	// m3: gains
	logic signed [VW+32:0] vkg, vkb;
	logic signed [VW+16:0] vg_s3, vkg_s3, vkb_s3;
	logic signed [NW+17:0] ag_s3;

	assign vkg = var_s2 * $signed({1'b0, gains.kg_green});
	assign vkb = var_s2 * $signed({1'b0, gains.kg_blue});

	always_ff @(posedge clk) begin
		if (en) begin
			vg_s3  <= var_s2 * $signed({1'b0, gains.grain});
			vkg_s3 <= $signed(vkg[VW+32:16]);
			vkb_s3 <= $signed(vkb[VW+32:16]);
			ag_s3  <= agen_s2 * $signed({1'b0, gains.aging});
		end
	end

	// m4: channel sums and clamp
	logic signed [CWD-1:0] agw, rs, gs, bs;
	logic [7:0]            red_s4, green_s4, blue_s4;

	assign agw = CWD'(ag_s3);
	assign rs  = BASE_R + CWD'(vg_s3);
	assign gs  = BASE_G + CWD'(vkg_s3) + (agw <<< 2) + agw;
	assign bs  = BASE_B + CWD'(vkb_s3) + (agw <<< 1) + agw;

	always_ff @(posedge clk) begin
		if (en) begin
			red_s4   <= clamp8(rs);
			green_s4 <= clamp8(gs);
			blue_s4  <= clamp8(bs);
		end
	end

	assign red   = red_s4;
	assign green = green_s4;
	assign blue  = blue_s4;

endmodule

### sv/paper_texture_noise_shader_top.sv
// top level of the procedural paper texture shader
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   pixel_x, pixel_y
//   out      source     out_valid / out_stall red, green, blue
//   cfg      sink       cfg_write             cfg_index, cfg_data
//
// one pixel per clock sustained unless the output stalls; from transfer to result each
// pixel passes 1 coordinate stage, 7 noise stages, 2 fractal divide stages and 4 mix
// stages; the 32x32 hash multipliers in the noise octaves set the stage depth
// the whole pipeline advances together; it holds only while a result sits in
// the output register and out_stall is high, so in_stall follows that
// reset clears the valid chain and loads the register reset values
module paper_texture_noise_shader_top import ptn_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue,
	input  logic                  cfg_write,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	localparam int CW  = COORD_BITS + INV_BITS;
	localparam int NW  = FRAC_BITS + 4;
	localparam int LAT = 1 + NOISE_LAT + FRACTAL_LAT + MIX_LAT;

	// configuration registers; seed is kept pre-multiplied by its hash constant
	logic [31:0]         seed_c_q;
	logic [INV_BITS-1:0] inv_w_q, inv_h_q;
	gain_cfg_t           gains_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_c_q         <= '0;
			inv_w_q          <= '0;
			inv_h_q          <= '0;
			gains_q.grain    <= GRAIN_RESET;
			gains_q.aging    <= '0;
			gains_q.kg_green <= KG_GREEN_RESET;
			gains_q.kg_blue  <= KG_BLUE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SEED: begin
					seed_c_q <= cfg_data * HASH_S;
				end
				REG_INV_WIDTH: begin
					inv_w_q <= cfg_data[INV_BITS-1:0];
				end
				REG_INV_HEIGHT: begin
					inv_h_q <= cfg_data[INV_BITS-1:0];
				end
				REG_GRAIN: begin
					gains_q.grain    <= cfg_data[15:0];
					gains_q.kg_green <= cfg_data[15:0] * COEF_GREEN;
					gains_q.kg_blue  <= cfg_data[15:0] * COEF_BLUE;
				end
				REG_AGING: begin
					gains_q.aging <= cfg_data[15:0];
				end
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	// global advance: blocked only by a stalled result in the output register
	logic            en;
	logic [LAT-1:0]  vld_q;

	assign en        = !(vld_q[LAT-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	// coordinate stage: pixel times reciprocal, q.24
	logic [CW-1:0] cx_s1, cy_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= pixel_x * inv_w_q;
			cy_s1 <= pixel_y * inv_h_q;
		end
	end

	// four noise layers, all with the same latency
	logic signed [NW-1:0] broad, mid, fine, age;

	ptn_fractal #(
		.CW(CW), .FRAC_BITS(FRAC_BITS),
		.SCALE(BROAD_SCALE), .OFFSET(BROAD_OFF), .OCTAVES(BROAD_OCT)
	) u_broad (
		.clk(clk), .en(en), .cx(cx_s1), .cy(cy_s1), .seed_c(seed_c_q), .frac(broad)
	);

	ptn_fractal #(
		.CW(CW), .FRAC_BITS(FRAC_BITS),
		.SCALE(MEDIUM_SCALE), .OFFSET(MEDIUM_OFF), .OCTAVES(MEDIUM_OCT)
	) u_medium (
		.clk(clk), .en(en), .cx(cx_s1), .cy(cy_s1), .seed_c(seed_c_q), .frac(mid)
	);

	ptn_fractal #(
		.CW(CW), .FRAC_BITS(FRAC_BITS),
		.SCALE(FINE_SCALE), .OFFSET(FINE_OFF), .OCTAVES(FINE_OCT)
	) u_fine (
		.clk(clk), .en(en), .cx(cx_s1), .cy(cy_s1), .seed_c(seed_c_q), .frac(fine)
	);

	ptn_fractal #(
		.CW(CW), .FRAC_BITS(FRAC_BITS),
		.SCALE(AGE_SCALE), .OFFSET(AGE_OFF), .OCTAVES(AGE_OCT)
	) u_age (
		.clk(clk), .en(en), .cx(cx_s1), .cy(cy_s1), .seed_c(seed_c_q), .frac(age)
	);

	// blend, gains and clamp; its last stage is the output register
	ptn_mix #(
		.FRAC_BITS(FRAC_BITS)
	) u_mix (
		.clk(clk),
		.en(en),
		.broad(broad),
		.mid(mid),
		.fine(fine),
		.age(age),
		.gains(gains_q),
		.red(red),
		.green(green),
		.blue(blue)
	);

endmodule

### sv/ptn_checker.sv
// port-level checker for the paper texture shader, bound to the top level
`include "paper_texture_noise_shader_top_defines.svh"

module ptn_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);

	// the input side only waits on a held result
	`PTN_ASSERT_IMP(a_stall_only_when_held, in_stall, out_valid && out_stall, "input stalled without a held result")

	// a held result blocks new transfers into the pipe
	`PTN_ASSERT_IMP(a_held_blocks_input, out_valid && out_stall, in_stall, "input taken while result held")

	// a stalled result stays
	`PTN_ASSERT_NXT(a_out_valid_holds, out_valid && out_stall, out_valid, "result dropped under stall")

	// a stalled result keeps its value
	`PTN_ASSERT_NXT(a_out_data_holds, out_valid && out_stall, $stable(red) && $stable(green) && $stable(blue), "result changed under stall")

endmodule

bind paper_texture_noise_shader_top ptn_checker u_ptn_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.red(red),
	.green(green),
	.blue(blue)
);

### test/tb_pixel_checker.sv
// checker for the paper texture shader: predicts each pixel color and compares it
`timescale 1ns / 1ps
module tb_pixel_checker import ptn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [11:0] pixel_x,
	input  logic [11:0] pixel_y,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	localparam longint ONE = 64'sd1 << 16;

	logic [31:0] seed_r;
	logic [23:0] invw_r, invh_r;
	logic [15:0] grain_r, aging_r;
	logic [23:0] color_q[$];

	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic logic [31:0] mix_hash(logic [31:0] cx, logic [31:0] cy, logic [31:0] s);
		logic [31:0] h;
		h = cx * HASH_X + cy * HASH_Y + s * HASH_S;
		h = (h ^ (h >> 13)) * HASH_MIX;
		return h ^ (h >> 16);
	endfunction

	function automatic longint grad_of(logic [31:0] h);
		return longint'({1'b0, h[30:0]} >> 14) - ONE;
	endfunction

	function automatic longint lerp_q(longint a, longint b, longint t);
		return a + floor_shr((b - a) * t, 16);
	endfunction

	function automatic longint fade(longint f);
		longint f2;
		f2 = floor_shr(f * f, 16);
		return floor_shr(f2 * (3 * ONE - 2 * f), 16);
	endfunction

	function automatic longint grad_noise(logic [63:0] px, logic [63:0] py, logic [31:0] s);
		logic [31:0] ix, iy;
		longint fx, fy, sx, sy, v00, v10, v01, v11;
		ix = px[55:24];
		iy = py[55:24];
		fx = longint'(px[23:8]);
		fy = longint'(py[23:8]);
		sx = fade(fx);
		sy = fade(fy);
		v00 = floor_shr((fx + fy) * grad_of(mix_hash(ix, iy, s)), 16);
		v10 = floor_shr((fx - ONE + fy) * grad_of(mix_hash(ix + 1, iy, s)), 16);
		v01 = floor_shr((fx + fy - ONE) * grad_of(mix_hash(ix, iy + 1, s)), 16);
		v11 = floor_shr((fx + fy - 2 * ONE) * grad_of(mix_hash(ix + 1, iy + 1, s)), 16);
		return lerp_q(lerp_q(v00, v10, sx), lerp_q(v01, v11, sx), sy);
	endfunction

	function automatic longint fbm(logic [63:0] cx, logic [63:0] cy, int scale, int off,
		int octs);
		longint sum;
		sum = 0;
		for (int i = 0; i < octs; i++)
			sum += grad_noise((cx * scale) << i, (cy * scale) << i,
				seed_r + off + i) * (64'sd1 << (octs - 1 - i));
		return sum / ((64'sd1 << octs) - 1);
	endfunction

	function automatic logic [7:0] clamp_chan(longint v);
		longint c;
		c = v / (64'sd1 << 24);
		if (c < 0) return 8'd0;
		if (c > 255) return 8'd255;
		return c[7:0];
	endfunction

	function automatic logic [23:0] shade(logic [11:0] x, logic [11:0] y);
		logic [63:0] cx, cy;
		longint br, md, fn, ag, vr, vg, an, agg, r, g, b;
		cx = 64'(x) * 64'(invw_r);
		cy = 64'(y) * 64'(invh_r);
		br = fbm(cx, cy, BROAD_SCALE, BROAD_OFF, BROAD_OCT);
		md = fbm(cx, cy, MEDIUM_SCALE, MEDIUM_OFF, MEDIUM_OCT);
		fn = fbm(cx, cy, FINE_SCALE, FINE_OFF, FINE_OCT);
		ag = fbm(cx, cy, AGE_SCALE, AGE_OFF, AGE_OCT);
		vr = floor_shr(br * 157286 + md * 81920 + fn * 42598, 16);
		vg = vr * longint'(grain_r);
		an = floor_shr(ag, 1) + (ONE >>> 1);
		agg = an * longint'(aging_r);
		r = 251 * (64'sd1 << 24) + vg;
		g = 249 * (64'sd1 << 24) + floor_shr(vg * 60293, 16) + agg * 5;
		b = 242 * (64'sd1 << 24) + floor_shr(vg * 51118, 16) + agg * 3;
		return {clamp_chan(r), clamp_chan(g), clamp_chan(b)};
	endfunction

	assign pending = color_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [23:0] want;
		if (!arst_n) begin
			seed_r <= 0; invw_r <= 0; invh_r <= 0; grain_r <= 16'd256; aging_r <= 0;
			fail_count <= 0;
			color_q.delete();
		end else begin
			if (in_valid && !in_stall)
				color_q.push_back(shade(pixel_x, pixel_y));
			if (out_valid && !out_stall) begin
				if (color_q.size() == 0) begin
					$display("%0t: unexpected pixel %h %h %h", $time, red, green, blue);
					fail_count <= fail_count + 1;
				end else begin
					want = color_q.pop_front();
					if (want !== {red, green, blue}) begin
						$display("%0t: pixel mismatch expected %h %h %h actual %h %h %h",
							$time, want[23:16], want[15:8], want[7:0], red, green, blue);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_write)
				case (cfg_index)
					REG_SEED:       seed_r <= cfg_data;
					REG_INV_WIDTH:  invw_r <= cfg_data[23:0];
					REG_INV_HEIGHT: invh_r <= cfg_data[23:0];
					REG_GRAIN:      grain_r <= cfg_data[15:0];
					REG_AGING:      aging_r <= cfg_data[15:0];
					default: ;
				endcase
		end
	end
endmodule

### test/tb_top.sv
// testbench top for the paper texture shader: stimulus, pressure and verdict
`timescale 1ns / 1ps
module tb_top import ptn_pkg::*;;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_write;
	logic [11:0] pixel_x, pixel_y;
	logic [7:0] red, green, blue;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	int fail_count, pending;
	// receiver modes: 0 random stalls, 1 no stalls, 2 long hold-off
	int sink_mode;
	int quiet_cycles;
	bit stim_done;

	paper_texture_noise_shader_top dut (.*);
	tb_pixel_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// receiver side stall pattern
	initial begin
		int hold;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (sink_mode == 2) begin
				// long hold-off counted here so the pipe fills and in_stall rises
				out_stall <= 1;
				for (hold = 0; hold < 60; hold++) @(posedge clk);
				out_stall <= 0;
				sink_mode = 0;
			end else if (sink_mode == 1)
				out_stall <= 0;
			else
				out_stall <= ($urandom_range(99) < 30);
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// one pixel transfer, with optional random idle before it
	task automatic send_pixel(logic [11:0] x, logic [11:0] y, bit idle);
		while (idle && $urandom_range(99) < 30) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		pixel_x <= x;
		pixel_y <= y;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// wait for all colors to drain, plus pipeline depth
	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 0;
	endtask

	task automatic set_all(logic [31:0] sd, logic [31:0] iw, logic [31:0] ih,
		logic [31:0] gr, logic [31:0] ag);
		write_reg(REG_SEED, sd);
		write_reg(REG_INV_WIDTH, iw);
		write_reg(REG_INV_HEIGHT, ih);
		write_reg(REG_GRAIN, gr);
		write_reg(REG_AGING, ag);
		@(posedge clk);
	endtask

	initial begin
		quiet_cycles = 0;
		sink_mode = 0;
		in_valid = 0; pixel_x = 0; pixel_y = 0;
		cfg_write = 0; cfg_index = 0; cfg_data = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset values: zero reciprocals make every coordinate 0
		send_pixel(12'd0, 12'd0, 0);
		send_pixel(12'hfff, 12'hfff, 0);
		drain();

		// directed corners under typical and extreme settings
		set_all(32'h1234_5678, 24'd16384, 24'd16384, 16'd256, 16'd256);
		send_pixel(12'd0, 12'd0, 0);
		send_pixel(12'hfff, 12'd0, 0);
		send_pixel(12'd0, 12'hfff, 0);
		send_pixel(12'hfff, 12'hfff, 0);
		send_pixel(12'h555, 12'haaa, 0);
		send_pixel(12'haaa, 12'h555, 0);
		drain();
		// extreme gains force channel clamping; bits above width are ignored
		set_all(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_pixel(12'd0, 12'd0, 0);
		send_pixel(12'hfff, 12'hfff, 0);
		send_pixel(12'd1, 12'd2, 0);
		send_pixel(12'h800, 12'h7ff, 0);
		drain();
		// zero gains, one zero reciprocal, and an unknown register index
		set_all(32'd0, 24'd0, 24'd4096, 16'd0, 16'd0);
		cfg_write <= 1; cfg_index <= 3'd7; cfg_data <= 32'hffff_ffff;
		@(posedge clk);
		cfg_write <= 0;
		send_pixel(12'd100, 12'd200, 0);
		send_pixel(12'hfff, 12'h001, 0);
		drain();

		// random phases of ~380 pixels each under random settings
		for (int ph = 0; ph < 5; ph++) begin
			set_all($urandom, (ph == 4) ? 24'hffffff : $urandom_range(24'hffffff),
				$urandom_range(24'hffffff), $urandom_range(ph == 2 ? 16'hffff : 1024),
				$urandom_range(ph == 3 ? 16'hffff : 1024));
			for (int k = 0; k < 380; k++) begin
				if (ph == 1 && k == 0) sink_mode = 1;
				if (ph == 1 && k == 150) sink_mode = 0;
				if (ph == 2 && k == 50) sink_mode = 2;
				send_pixel(12'($urandom), 12'($urandom), !(ph == 1 && k < 150));
				// sender pause until everything has come back
				if (ph == 3 && k == 200) begin
					in_valid <= 0;
					while (pending != 0) @(posedge clk);
				end
			end
			drain();
		end

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

### files.f
+incdir+sv
sv/ptn_pkg.sv
sv/ptn_noise.sv
sv/ptn_fractal.sv
sv/ptn_mix.sv
sv/paper_texture_noise_shader_top.sv
sv/ptn_checker.sv
test/tb_pixel_checker.sv
test/tb_top.sv
